>>> hw/rtl/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// Holds the request/response payload structs and the controller/datapath command and status.
// No dependencies.
`default_nettype none

package bpa_pkg;

    localparam int NUM_PAGES = 65536;
    localparam int PAGE_W    = 16;
    localparam int CNT_W     = 17;
    localparam int PV_W      = 18;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = $clog2(NUM_WORDS);
    localparam int RUN_W     = BIT_W + 1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2,
        OP_QUERY = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [PAGE_W-1:0]  start_page;
        logic [CNT_W-1:0]   page_count;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  result_page;
        logic               ok;
        logic               any_used;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic alloc_ok;
        logic range_load;
        logic rd;
        logic wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    clear_last;
        logic    lim_zero;
        logic    count_zero;
        logic    range_empty;
        logic    found;
        logic    scan_fail;
        logic    range_last;
        logic    out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/bpa_ctrl.sv
// Controller of the bitmap page allocator: one-hot state machine sequencing clear,
// scan, range update and response. Depends on bpa_pkg.
`default_nettype none

module bpa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bpa_pkg::sts_t sts,
    output bpa_pkg::cmd_t      cmd
);
    import bpa_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR      = 8'b0000_0001,
        S_IDLE       = 8'b0000_0010,
        S_DISPATCH   = 8'b0000_0100,
        S_SCAN       = 8'b0000_1000,
        S_RANGE_LOAD = 8'b0001_0000,
        S_RANGE_RD   = 8'b0010_0000,
        S_RANGE_WR   = 8'b0100_0000,
        S_FINISH     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.op == OP_ALLOC)
                begin
                    if (sts.lim_zero)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (sts.count_zero)
                    begin
                        cmd.alloc_ok = 1'b1;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else if (sts.range_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_RANGE_LOAD;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.found)
                begin
                    // mark the run just found as used
                    cmd.alloc_ok = 1'b1;
                    state_next   = S_RANGE_LOAD;
                end
                else if (sts.scan_fail)
                begin
                    state_next = S_FINISH;
                end
            end
            S_RANGE_LOAD:
            begin
                cmd.range_load = 1'b1;
                state_next     = S_RANGE_RD;
            end
            S_RANGE_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_RANGE_WR;
            end
            S_RANGE_WR:
            begin
                cmd.wr = 1'b1;
                if (sts.range_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_RANGE_RD;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/bpa_datapath.sv
// Datapath of the bitmap page allocator: used-page map memory, first-fit scan pipeline,
// run read-modify-write, limit register and response register. Depends on bpa_pkg.
`default_nettype none

module bpa_datapath (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bpa_pkg::cmd_t           cmd,
    output bpa_pkg::sts_t                sts,
    input  wire bpa_pkg::req_t           req,
    input  wire logic                    cfg_valid,
    input  wire logic [bpa_pkg::CNT_W-1:0] cfg_data,
    input  wire logic                    rsp_stall,
    output logic                         rsp_valid,
    output bpa_pkg::rsp_t                rsp
);
    import bpa_pkg::*;

    localparam logic [WORD_W-1:0] WORD_ONES = '1;
    localparam logic [BIT_W-1:0]  BIT_MAX   = BIT_W'(WORD_W - 1);

    // map memory
    logic [WORD_W-1:0]  mem [NUM_WORDS];
    logic [WORD_W-1:0]  q_reg;
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;

    // control registers
    logic [CNT_W-1:0]   total_reg;
    logic [WADDR_W-1:0] clr_addr_reg;
    logic               rsp_valid_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               issue_done_reg;
    logic [WADDR_W-1:0] scan_addr_reg;

    // request and result registers
    opcode_t            op_reg;
    logic [PAGE_W-1:0]  start_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   lim_reg;
    logic [PAGE_W-1:0]  res_page_reg;
    logic               ok_reg;
    logic               any_reg;
    rsp_t               rsp_reg;

    // scan pipeline
    logic [WADDR_W-1:0] w1_reg;
    logic [WADDR_W-1:0] w2_reg;
    logic               a_free_reg;
    logic [RUN_W-1:0]   a_l0_reg;
    logic [RUN_W-1:0]   a_t_reg;
    logic               a_gany_reg;
    logic [BIT_W-1:0]   a_gpos_reg;
    logic [CNT_W-1:0]   run_reg;

    // run update
    logic [WADDR_W-1:0] rng_word_reg;
    logic [WADDR_W-1:0] rng_last_reg;
    logic [BIT_W-1:0]   rng_lo_reg;
    logic [BIT_W-1:0]   rng_hi_reg;
    logic               rng_first_reg;

    logic [CNT_W-1:0]   lim_m1;
    logic [WADDR_W-1:0] lim_last_word;
    logic [BIT_W-1:0]   lim_hi;

    logic [CNT_W-1:0]   lim_next;
    logic [PV_W-1:0]    req_end;

    // stage A
    logic [WORD_W-1:0]  a_free_bits;
    logic               a_all_free;
    logic [RUN_W-1:0]   a_l0;
    logic [RUN_W-1:0]   a_t;
    logic [WORD_W-1:0]  a_g;
    logic               a_gany;
    logic [BIT_W-1:0]   a_gpos;
    logic [WORD_W-1:0]  h [RUN_W];
    logic [RUN_W-1:0]   g_off;

    // stage B
    logic [PV_W-1:0]    w2_base;
    logic               fit_lead;
    logic               fit_inner;
    logic               found_now;
    logic [PV_W-1:0]    found_start;

    // run setup and modify
    logic [PAGE_W-1:0]  rng_start;
    logic [PV_W-1:0]    rng_end;
    logic [PV_W-1:0]    rng_stop;
    logic [PV_W-1:0]    rng_lastp;
    logic               rng_at_last;
    logic [BIT_W-1:0]   lo_eff;
    logic [BIT_W-1:0]   hi_eff;
    logic [WORD_W-1:0]  rng_mask;
    logic [WORD_W-1:0]  mod_word;

    assign lim_m1        = lim_reg - CNT_W'(1);
    assign lim_last_word = lim_m1[WADDR_W+BIT_W-1:BIT_W];
    assign lim_hi        = lim_m1[BIT_W-1:0];

    assign lim_next = (total_reg > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : total_reg;
    assign req_end  = PV_W'(req.start_page) + PV_W'(req.page_count);

    // ---------------- memory ----------------
    assign rd_en   = (cmd.scan && !issue_done_reg) || cmd.rd;
    assign rd_addr = cmd.rd ? rng_word_reg : scan_addr_reg;
    assign wr_en   = cmd.clear || (cmd.wr && (op_reg != OP_QUERY));
    assign wr_addr = cmd.clear ? clr_addr_reg : rng_word_reg;
    assign wr_data = cmd.clear ? '0 : mod_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // ---------------- scan stage A: per-word features ----------------
    always_comb
    begin
        a_free_bits = ~q_reg;
        if (w1_reg == lim_last_word)
        begin
            // pages at or above the limit count as used
            a_free_bits = a_free_bits & (WORD_ONES >> (BIT_MAX - lim_hi));
        end
        a_all_free = &a_free_bits;

        a_l0 = RUN_W'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!a_free_bits[i])
            begin
                a_l0 = RUN_W'(i);
            end
        end

        a_t = RUN_W'(WORD_W);
        for (int i = 0; i < WORD_W; i++)
        begin
            if (!a_free_bits[i])
            begin
                a_t = RUN_W'(WORD_W - 1 - i);
            end
        end

        // h[k] bit j set when 2**k pages from j upward are free
        h[0] = a_free_bits;
        for (int k = 1; k < RUN_W; k++)
        begin
            h[k] = h[k-1] & (h[k-1] >> (1 << (k - 1)));
        end
        a_g   = WORD_ONES;
        g_off = '0;
        for (int b = 0; b < RUN_W; b++)
        begin
            if (count_reg[b])
            begin
                a_g   = a_g & (h[b] >> g_off);
                g_off = g_off + RUN_W'(1 << b);
            end
        end
        a_gany = |a_g;

        a_gpos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (a_g[i])
            begin
                a_gpos = BIT_W'(i);
            end
        end
    end

    // ---------------- scan stage B: run tracking ----------------
    assign w2_base   = PV_W'({w2_reg, {BIT_W{1'b0}}});
    assign fit_lead  = (PV_W'(run_reg) + PV_W'(a_l0_reg)) >= PV_W'(count_reg);
    assign fit_inner = a_gany_reg && (count_reg <= CNT_W'(WORD_W));
    assign found_now = cmd.scan && v2_reg && (fit_lead || fit_inner);
    assign found_start = fit_lead ? (w2_base - PV_W'(run_reg))
                                  : (w2_base + PV_W'(a_gpos_reg));

    // ---------------- run update ----------------
    assign rng_start = (op_reg == OP_ALLOC) ? res_page_reg : start_reg;
    assign rng_end   = PV_W'(rng_start) + PV_W'(count_reg);
    assign rng_stop  = (rng_end > PV_W'(NUM_PAGES)) ? PV_W'(NUM_PAGES) : rng_end;
    assign rng_lastp = rng_stop - PV_W'(1);

    assign rng_at_last = (rng_word_reg == rng_last_reg);
    assign lo_eff      = rng_first_reg ? rng_lo_reg : '0;
    assign hi_eff      = rng_at_last ? rng_hi_reg : BIT_MAX;
    assign rng_mask    = (WORD_ONES << lo_eff) & (WORD_ONES >> (BIT_MAX - hi_eff));

    always_comb
    begin
        case (op_reg)
            OP_FREE:  mod_word = q_reg & ~rng_mask;
            OP_QUERY: mod_word = q_reg;
            default:  mod_word = q_reg | rng_mask;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            clr_addr_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            issue_done_reg <= 1'b0;
            scan_addr_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                total_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + WADDR_W'(1);
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            v1_reg <= cmd.scan && !issue_done_reg;
            v2_reg <= cmd.scan && v1_reg;

            if (cmd.load)
            begin
                issue_done_reg <= 1'b0;
                scan_addr_reg  <= '0;
            end
            else if (cmd.scan && !issue_done_reg)
            begin
                scan_addr_reg <= scan_addr_reg + WADDR_W'(1);
                if (scan_addr_reg == lim_last_word)
                begin
                    issue_done_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= req.opcode;
            start_reg    <= req.start_page;
            count_reg    <= req.page_count;
            lim_reg      <= lim_next;
            res_page_reg <= '0;
            ok_reg       <= (req.opcode != OP_ALLOC) && (req_end <= PV_W'(NUM_PAGES));
            any_reg      <= 1'b0;
            run_reg      <= '0;
        end
        else
        begin
            if (cmd.alloc_ok)
            begin
                ok_reg <= 1'b1;
            end
            if (found_now)
            begin
                res_page_reg <= found_start[PAGE_W-1:0];
            end
            else if (cmd.scan && v2_reg)
            begin
                run_reg <= a_free_reg ? (run_reg + CNT_W'(WORD_W)) : CNT_W'(a_t_reg);
            end
            if (cmd.wr && (op_reg == OP_QUERY) && (|(q_reg & rng_mask)))
            begin
                any_reg <= 1'b1;
            end
        end

        w1_reg     <= scan_addr_reg;
        w2_reg     <= w1_reg;
        a_free_reg <= a_all_free;
        a_l0_reg   <= a_l0;
        a_t_reg    <= a_t;
        a_gany_reg <= a_gany;
        a_gpos_reg <= a_gpos;

        if (cmd.range_load)
        begin
            rng_word_reg  <= rng_start[WADDR_W+BIT_W-1:BIT_W];
            rng_last_reg  <= rng_lastp[WADDR_W+BIT_W-1:BIT_W];
            rng_lo_reg    <= rng_start[BIT_W-1:0];
            rng_hi_reg    <= rng_lastp[BIT_W-1:0];
            rng_first_reg <= 1'b1;
        end
        else if (cmd.wr)
        begin
            rng_word_reg  <= rng_word_reg + WADDR_W'(1);
            rng_first_reg <= 1'b0;
        end

        if (cmd.out_load)
        begin
            rsp_reg.result_page <= res_page_reg;
            rsp_reg.ok          <= ok_reg;
            rsp_reg.any_used    <= any_reg;
        end
    end

    // ---------------- status ----------------
    assign sts.op          = op_reg;
    assign sts.clear_last  = (clr_addr_reg == WADDR_W'(NUM_WORDS - 1));
    assign sts.lim_zero    = (lim_reg == '0);
    assign sts.count_zero  = (count_reg == '0);
    assign sts.range_empty = (count_reg == '0) || (PV_W'(start_reg) >= PV_W'(NUM_PAGES));
    assign sts.found       = found_now;
    assign sts.scan_fail   = cmd.scan && v2_reg && !(fit_lead || fit_inner)
                             && (w2_reg == lim_last_word);
    assign sts.range_last  = rng_at_last;
    assign sts.out_free    = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_page_allocator_core.sv
// Bitmap page allocator, first fit, one used bit per page in a 32-bit-word map memory.
// After reset a clearing pass writes the 2048 map words, one a cycle; requests wait.
// Free, mark, query: a read-modify-write of each map word that the run covers.
// Allocate: a scan of the map words up to the fit, one word a cycle, then the read-modify-write of the run found.
// One request in flight; the next is taken while the response register still waits.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
`default_nettype none

module bitmap_page_allocator_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire bpa_pkg::req_t             req,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output bpa_pkg::rsp_t                  rsp,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [bpa_pkg::CNT_W-1:0] cfg_data
);
    import bpa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_bitmap_page_allocator_core.sv
`timescale 1ns / 100ps
// Testbench for bitmap_page_allocator_core: directed and random page requests checked against
// a bit-exact used-map predictor kept in a small scoreboard class.
// Depends on bpa_pkg and the allocator RTL.

module tb_bitmap_page_allocator_core;
    import bpa_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_LIMIT    = 50000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 150;
    localparam int REPORT_MAX    = 10;
    localparam int MAX_COUNT     = 131071;
    localparam int MAX_PAGE      = 65535;

    typedef struct packed {
        logic [PAGE_W-1:0] first;
        logic [CNT_W-1:0]  count;
    } page_run_t;

    class page_map_scoreboard;
        bit          used_map [NUM_PAGES];
        int unsigned total_pages;
        rsp_t        awaited [$];
        int          mismatches;

        function void set_total_pages(int unsigned value);
            total_pages = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted request to the used map and queue its response.
        function rsp_t note_request(req_t item);
            rsp_t        exp;
            int unsigned limit, count, first, stop, run, p;
            bit          found;
            exp   = '0;
            count = item.page_count;
            first = item.start_page;
            if (item.opcode == OP_ALLOC)
            begin
                limit = (total_pages > NUM_PAGES) ? NUM_PAGES : total_pages;
                found = 1'b0;
                if (limit != 0 && count == 0)
                begin
                    found = 1'b1;
                    first = 0;
                end
                else if (limit != 0)
                begin
                    run = 0;
                    for (p = 0; p < limit && !found; p++)
                    begin
                        if (used_map[p])
                            run = 0;
                        else
                        begin
                            run++;
                            if (run == count)
                            begin
                                found = 1'b1;
                                first = p + 1 - count;
                            end
                        end
                    end
                end
                if (found)
                begin
                    for (p = first; p < first + count; p++)
                        used_map[p] = 1'b1;
                    exp.result_page = PAGE_W'(first);
                    exp.ok          = 1'b1;
                end
            end
            else
            begin
                stop   = first + count;
                exp.ok = 1'b1;
                // drop the part of the run beyond the map
                if (stop > NUM_PAGES)
                begin
                    stop   = NUM_PAGES;
                    exp.ok = 1'b0;
                end
                for (p = first; p < stop; p++)
                begin
                    case (item.opcode)
                        OP_FREE: used_map[p] = 1'b0;
                        OP_MARK: used_map[p] = 1'b1;
                        default: if (used_map[p]) exp.any_used = 1'b1;
                    endcase
                end
            end
            awaited.push_back(exp);
            return exp;
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch at %0t: response with none pending: page %0d ok %0b any %0b",
                             $time, got.result_page, got.ok, got.any_used);
                return;
            end
            exp = awaited.pop_front();
            if (got.result_page !== exp.result_page || got.ok !== exp.ok ||
                got.any_used !== exp.any_used)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch at %0t: result_page exp %0d got %0d, ok exp %0b got %0b, %s",
                             $time, exp.result_page, got.result_page, exp.ok, got.ok,
                             $sformatf("any_used exp %0b got %0b", exp.any_used, got.any_used));
            end
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_t             req       = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b1;
    rsp_t             rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;

    bit                 steady     = 1'b0;
    int unsigned        page_limit = 0;
    page_run_t          live_runs [$];
    page_map_scoreboard sb;

    int unsigned limit_steps [10] = '{16, 65536, 1, 300, 131071, 0, 2048, 65535, 8, 1000};

    bitmap_page_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_response(rsp);
    end

    initial
    begin : rsp_side
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 9);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (rsp_valid !== 1'b1);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid === 1'b1 && req_stall === 1'b0) ||
                (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
                (cfg_valid === 1'b1 && cfg_ready === 1'b1) || !rst_n)
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic write_total_pages(input int unsigned value);
        cfg_data  <= CNT_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_total_pages(value);
        page_limit = (value > NUM_PAGES) ? NUM_PAGES : value;
    endtask

    // Present one request, hold it until accepted, then predict its response.
    task automatic send_op(input opcode_t op, input int unsigned first, input int unsigned count);
        req_t      item;
        rsp_t      predicted;
        page_run_t run;
        int        gap;
        item.opcode     = op;
        item.start_page = PAGE_W'(first);
        item.page_count = CNT_W'(count);
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall !== 1'b0);
        predicted = sb.note_request(item);
        if (op == OP_ALLOC && predicted.ok && item.page_count != 0)
        begin
            run.first = predicted.result_page;
            run.count = item.page_count;
            live_runs.push_back(run);
        end
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random();
        int unsigned pick, count, first, span, top, idx;
        page_run_t   run;
        opcode_t     op;
        pick  = $urandom_range(0, 99);
        span  = ((page_limit > 64) ? page_limit : 64) + 64;
        if (span > NUM_PAGES)
            span = NUM_PAGES;
        first = $urandom_range(0, span - 1);
        count = $urandom_range(1, 16);
        op    = OP_MARK;
        if (pick < 38)
        begin
            op    = OP_ALLOC;
            first = $urandom_range(0, MAX_PAGE);
            pick  = $urandom_range(0, 99);
            top   = (page_limit + 2 > 4096) ? 4096 : page_limit + 2;
            if (pick < 3)
                count = 0;
            else if (pick < 60)
                count = $urandom_range(1, 8);
            else if (pick < 90)
                count = $urandom_range(1, 64);
            else if (pick < 97)
                count = $urandom_range(1, top);
            else
                count = $urandom_range(1, NUM_PAGES);
        end
        else if (pick < 63 && live_runs.size() != 0)
        begin
            op    = OP_FREE;
            idx   = $urandom_range(0, live_runs.size() - 1);
            run   = live_runs[idx];
            first = run.first;
            count = run.count;
            // keep one run in ten listed so it is freed a second time
            if ($urandom_range(0, 9) != 0)
                live_runs.delete(idx);
        end
        else if (pick < 80)
        begin
            op = OP_QUERY;
            if (live_runs.size() != 0 && $urandom_range(0, 1) == 1)
            begin
                run   = live_runs[$urandom_range(0, live_runs.size() - 1)];
                first = run.first;
                count = run.count + $urandom_range(0, 1);
            end
        end
        else if (pick >= 90)
        begin
            op   = opcode_t'($urandom_range(1, 3));
            pick = $urandom_range(0, 4);
            if (pick < 2)
            begin
                first = $urandom_range(65000, MAX_PAGE);
                count = $urandom_range(0, MAX_COUNT);
            end
            else if (pick < 4)
            begin
                op    = opcode_t'($urandom_range(0, 3));
                first = $urandom_range(0, MAX_PAGE);
                count = $urandom_range(0, 3);
            end
            else
            begin
                first = $urandom_range(0, MAX_PAGE);
                count = $urandom_range(1, NUM_PAGES);
            end
        end
        send_op(op, first, count);
    endtask

    initial
    begin : main_flow
        int unsigned phase, n;
        sb = new;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // limit still zero from reset: every allocate fails
        send_op(OP_ALLOC, 0, 0);
        send_op(OP_ALLOC, 0, 5);
        wait_idle();

        write_total_pages(MAX_COUNT);
        send_op(OP_ALLOC, MAX_PAGE, 0);
        send_op(OP_ALLOC, 0, 1);
        send_op(OP_ALLOC, 0, NUM_PAGES);
        send_op(OP_MARK, MAX_PAGE, 1);
        send_op(OP_MARK, MAX_PAGE, 2);
        send_op(OP_QUERY, 0, NUM_PAGES);
        send_op(OP_QUERY, 10, 0);
        send_op(OP_FREE, 0, NUM_PAGES);
        send_op(OP_QUERY, 0, NUM_PAGES);
        send_op(OP_ALLOC, 0, NUM_PAGES);
        send_op(OP_ALLOC, 0, 1);
        send_op(OP_QUERY, MAX_PAGE, MAX_COUNT);
        send_op(OP_FREE, 0, MAX_COUNT);
        send_op(OP_MARK, 100, 5);
        send_op(OP_ALLOC, 0, 100);
        send_op(OP_ALLOC, 0, 10);
        send_op(OP_FREE, 3, 0);
        send_op(OP_MARK, 3, 0);
        send_op(OP_QUERY, 103, 1);
        send_op(OP_FREE, 0, 200);
        wait_idle();

        write_total_pages(1);
        send_op(OP_ALLOC, 0, 1);
        send_op(OP_ALLOC, 0, 1);
        send_op(OP_ALLOC, 0, 2);
        send_op(OP_FREE, 0, 1);
        live_runs.delete();

        for (phase = 0; phase < 10; phase++)
        begin
            wait_idle();
            write_total_pages(limit_steps[phase]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 25 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_random();
            end
        end
        wait_idle();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bpa_datapath.sv
hw/rtl/bitmap_page_allocator_core.sv
tb/sv/tb_bitmap_page_allocator_core.sv
